// File: rtl/core/tmte_pkg.sv
// ----------------------------------------------------------------------------
// tmte_pkg
// Shared constants, types and command codes of the text mode terminal engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tmte_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = ROWS * COLUMNS;
  localparam int SCROLL_N = (ROWS - 1) * COLUMNS;  // first cell of the bottom row

  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CELL_W = 16;

  // Field widths of the ports
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 7;

  // Character and cell constants
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h03;
  localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_COLOR, SPACE_CODE};

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Code with no command behind it; accepted and answered, changes nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Request to the cell walker
  typedef struct packed {
    logic start;
    logic scroll;   // 1: scroll then blank bottom row, 0: blank whole screen
  } walk_req_t;

  // Status from the cell walker
  typedef struct packed {
    logic busy;
    logic done;     // last write of a walk in this cycle
  } walk_stat_t;

  // One memory access cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // One result item
  typedef struct packed {
    logic [CELL_W-1:0]    cell_value;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/tmte_ram.sv
// ----------------------------------------------------------------------------
// tmte_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/tmte_walker.sv
// ----------------------------------------------------------------------------
// tmte_walker
// Walks the cell store one cell per cycle: scroll (copy each row up with the
// current color, then blank the bottom row), screen clear, and the reset fill.
// ----------------------------------------------------------------------------
`default_nettype none

module tmte_walker
  import tmte_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire walk_req_t            req_i,
  input  wire logic [COLOR_W-1:0]   color_i,
  input  wire logic [CELL_W-1:0]    rdata_i,
  output walk_stat_t                stat_o,
  output ram_req_t                  ram_o
);

  typedef enum logic [2:0] {
    W_IDLE   = 3'b001,
    W_SCROLL = 3'b010,
    W_FILL   = 3'b100
  } wstate_e;

  wstate_e           state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              init_q, init_d;

  // next state and memory access
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    init_d      = init_q;
    ram_o       = '0;
    stat_o.busy = (state_q != W_IDLE);
    stat_o.done = 1'b0;

    unique case (state_q)
      W_IDLE: begin
        if (req_i.start) begin
          cnt_d   = '0;
          state_d = req_i.scroll ? W_SCROLL : W_FILL;
        end
      end
      W_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle
        ram_o.re    = (cnt_q != ADDR_W'(SCROLL_N));
        ram_o.raddr = ADDR_W'(32'(cnt_q) + COLUMNS);
        ram_o.we    = (cnt_q != '0);
        ram_o.waddr = ADDR_W'(32'(cnt_q) - 1);
        ram_o.wdata = {color_i, rdata_i[CHAR_W-1:0]};
        if (cnt_q == ADDR_W'(SCROLL_N)) begin
          state_d = W_FILL;   // counter already sits on the bottom row
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      W_FILL: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = cnt_q;
        ram_o.wdata = init_q ? RESET_CELL : {color_i, SPACE_CODE};
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          stat_o.done = 1'b1;
          init_d      = 1'b0;
          state_d     = W_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  // reset starts the fill pass over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_FILL;
      cnt_q   <= '0;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tmte_outreg.sv
// ----------------------------------------------------------------------------
// tmte_outreg
// Output register of the result channel; frees itself on the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tmte_outreg
  import tmte_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         free_o,
  input  wire logic    ready_i,
  output logic         valid_o,
  output result_t      data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // slot can take a new result when empty or being drained
  assign free_o  = !valid_q || ready_i;
  assign valid_d = push_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/text_mode_terminal_engine.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_engine
// Character-cell terminal: cell store, cursor, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// Timing: while the output register is free, a put that does not scroll hands
// its result to it in the cycle it is taken, so such puts stream at one per
// cycle. A read goes through the registered memory read and the S_READ state.
// A clear walks every cell through the single write port of the cell store.
// A put that scrolls copies each row up through the store, one cell a cycle,
// then blanks the bottom row. After reset the store is filled with
// cyan-on-black spaces, during which in_ready_o is low. Write the color
// register only between commands: a clear or scroll in progress picks up a
// new color part way through. A result waits in an output register, and the
// next command is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_terminal_engine
  import tmte_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // color register write
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [COLOR_W-1:0]     cfg_text_color_i,
  // command channel
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [CMD_W-1:0]       cmd_i,
  input  wire logic [CHAR_W-1:0]      char_code_i,
  input  wire logic [OUT_ROW_W-1:0]   read_row_i,
  input  wire logic [OUT_COL_W-1:0]   read_col_i,
  // result channel
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [CELL_W-1:0]           cell_value_o,
  output logic [OUT_ROW_W-1:0]        cursor_row_o,
  output logic [OUT_COL_W-1:0]        cursor_col_o
);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_WALK = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ADDR_W-1:0]  base_q, base_d;     // row_q * COLUMNS
  logic [CELL_W-1:0]  hold_q, hold_d;
  logic [COLOR_W-1:0] color_q;

  walk_req_t          walk_req;
  walk_stat_t         walk_stat;
  ram_req_t           walk_ram, cmd_ram, ram_req;
  logic [CELL_W-1:0]  rdata;

  logic               finish;
  logic [CELL_W-1:0]  fin_val;
  logic               slot_free;
  logic               push;
  result_t            push_data, out_data;
  logic               read_ok;

  // color register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= RESET_COLOR;
    end else if (cfg_valid_i) begin
      color_q <= cfg_text_color_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign read_ok    = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLUMNS);

  // command sequencer
  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    base_d   = base_q;
    hold_d   = hold_q;
    walk_req = '0;
    cmd_ram  = '0;
    finish   = 1'b0;
    fin_val  = '0;

    unique case (state_q)
      S_INIT: begin
        if (walk_stat.done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_e'(cmd_i))
            CMD_PUT: begin
              if (char_code_i != NEWLINE_CODE) begin
                cmd_ram.we    = 1'b1;
                cmd_ram.waddr = base_q + ADDR_W'(col_q);
                cmd_ram.wdata = {color_q, char_code_i};
              end
              if (char_code_i == NEWLINE_CODE || col_q == COL_W'(COLUMNS - 1)) begin
                col_d = '0;
                if (row_q == ROW_W'(ROWS - 1)) begin
                  // past the last row: scroll, cursor stays on the last row
                  walk_req.start  = 1'b1;
                  walk_req.scroll = 1'b1;
                  state_d         = S_WALK;
                end else begin
                  row_d  = row_q + ROW_W'(1);
                  base_d = ADDR_W'(32'(base_q) + COLUMNS);
                  finish = 1'b1;
                end
              end else begin
                col_d  = col_q + COL_W'(1);
                finish = 1'b1;
              end
            end
            CMD_CLEAR: begin
              row_d          = '0;
              col_d          = '0;
              base_d         = '0;
              walk_req.start = 1'b1;
              state_d        = S_WALK;
            end
            CMD_READ: begin
              if (read_ok) begin
                cmd_ram.re    = 1'b1;
                cmd_ram.raddr = ADDR_W'(32'(read_row_i) * COLUMNS + 32'(read_col_i));
                state_d       = S_READ;
              end else begin
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;   // unused command: nothing changes
            end
          endcase
        end
      end
      S_READ: begin
        finish  = 1'b1;
        fin_val = rdata;
      end
      S_WALK: begin
        if (walk_stat.done) begin
          finish = 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hand the result to the output register, or park it
    if (finish) begin
      if (slot_free) begin
        state_d = S_IDLE;
      end else begin
        hold_d  = fin_val;
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      row_q   <= '0;
      col_q   <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      base_q  <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  // result assembly
  assign push = slot_free && (finish || state_q == S_EMIT);
  assign push_data.cell_value = (state_q == S_EMIT) ? hold_q : fin_val;
  assign push_data.cursor_row = OUT_ROW_W'(row_d);
  assign push_data.cursor_col = OUT_COL_W'(col_d);

  // memory port: walker owns it while busy
  assign ram_req = walk_stat.busy ? walk_ram : cmd_ram;

  tmte_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (walk_req),
    .color_i (color_q),
    .rdata_i (rdata),
    .stat_o  (walk_stat),
    .ram_o   (walk_ram)
  );

  tmte_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  tmte_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .free_o  (slot_free),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (out_data)
  );

  assign cell_value_o = out_data.cell_value;
  assign cursor_row_o = out_data.cursor_row;
  assign cursor_col_o = out_data.cursor_col;

endmodule

`default_nettype wire

// File: rtl/core/tmte_checker.sv
// ----------------------------------------------------------------------------
// tmte_checker
// Port-level checks of the text mode terminal engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmte_checker
  import tmte_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [CMD_W-1:0]     cmd_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [CELL_W-1:0]    cell_value_o,
  input wire logic [OUT_ROW_W-1:0] cursor_row_o,
  input wire logic [OUT_COL_W-1:0] cursor_col_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_value_o)
      && $stable(cursor_row_o) && $stable(cursor_col_o))
    else $error("stalled result changed");

  // the reported cursor is always on screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_row_o) < ROWS) && (32'(cursor_col_o) < COLUMNS))
    else $error("cursor off screen");

  // an unused command into an empty output gives a zero result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_UNUSED && !out_valid_o
      |=> out_valid_o && cell_value_o == '0)
    else $error("unused command result missing");

  // a clear walks the store, so no command is taken right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_CLEAR |=> !in_ready_o)
    else $error("command taken during clear");

endmodule

bind text_mode_terminal_engine tmte_checker u_tmte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .cell_value_o (cell_value_o),
  .cursor_row_o (cursor_row_o),
  .cursor_col_o (cursor_col_o)
);

`default_nettype wire
